FILE: rtl/pfc_pkg.sv
// Package: sizes, codes, sequencer states and the bucket hash of the page frame cache.
package pfc_pkg;

  localparam int FRAMES       = 256;
  localparam int HASH_BUCKETS = 256;
  localparam int FIDX_W       = $clog2(FRAMES);
  localparam int BKT_W        = $clog2(HASH_BUCKETS);
  localparam int LINK_W       = FIDX_W + 1;
  localparam int CNT_W        = $clog2(FRAMES + 1);
  localparam int PIN_W        = 16;
  localparam int WORD_W       = 32;
  localparam int ID_W         = 7 * WORD_W;
  localparam int FRAME_W      = 8;
  localparam int TOTAL_W      = 9;

  localparam logic [LINK_W-1:0] NONE   = LINK_W'(FRAMES);
  localparam logic [LINK_W-1:0] ANCHOR = LINK_W'(FRAMES);
  localparam logic [PIN_W-1:0]  PIN_MAX = '1;

  typedef enum logic [2:0] {
    STAT_HIT       = 3'd0,
    STAT_FREE      = 3'd1,
    STAT_RECYCLED  = 3'd2,
    STAT_NO_FRAME  = 3'd3,
    STAT_PINNED    = 3'd4,
    STAT_UNPINNED  = 3'd5,
    STAT_REL_ERR   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_HIT,
    ST_UNLINK,
    ST_MISS,
    ST_UH_ID,
    ST_UH_HEAD,
    ST_UH_WALK,
    ST_UL_RD,
    ST_INS_RD,
    ST_INS_WR,
    ST_REL_RD,
    ST_REL_PUSH,
    ST_RESP
  } state_t;

  // Bucket index: wrapping sum of the seven id words, low bits only.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [ID_W-1:0] id);
    logic [BKT_W-1:0] s;
    s = '0;
    for (int i = 0; i < 7; i++) begin
      s = s + id[i*WORD_W +: BKT_W];
    end
    return s;
  endfunction

endpackage

FILE: rtl/pfc_in_if.sv
// Interface: request channel of the page frame cache.
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] file_id_0;
  logic [31:0] file_id_1;
  logic [31:0] file_id_2;
  logic [31:0] file_id_3;
  logic [31:0] file_id_4;
  logic [31:0] file_id_5;
  logic [31:0] page_number;
  logic [7:0]  release_frame;

  modport source (output valid, cmd, file_id_0, file_id_1, file_id_2, file_id_3, file_id_4,
                  file_id_5, page_number, release_frame, input ready);
  modport sink (input valid, cmd, file_id_0, file_id_1, file_id_2, file_id_3, file_id_4,
                file_id_5, page_number, release_frame, output ready);
endinterface

FILE: rtl/pfc_out_if.sv
// Interface: result channel of the page frame cache.
interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_index;
  logic [15:0] pin_count;
  logic [8:0]  free_frames;
  logic [8:0]  lru_frames;

  modport source (output valid, status, frame_index, pin_count, free_frames, lru_frames,
                  input ready);
  modport sink (input valid, status, frame_index, pin_count, free_frames, lru_frames,
                output ready);
endinterface

FILE: rtl/pfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/page_frame_cache_lru.sv
// Page frame cache with hashed lookup and LRU recycling, run by a small sequencer.
// Fetch walks the bucket chain; a hit on an unpinned frame also takes it off the LRU list;
//   a recycling miss also walks the victim's old chain to unhash it.
// Throughput: one request at a time; each chain step is one read of the link memory.
// Reset (rst_n low, synchronous): empty buckets, empty LRU list, full free list, no pins;
//   no clearing pass, the block takes a request in the first cycle after reset.
module page_frame_cache_lru (
  input logic       clk,
  input logic       rst_n,
  pfc_in_if.sink    in_ch,
  pfc_out_if.source out_ch
);

  localparam int FW = pfc_pkg::FIDX_W;
  localparam int LW = pfc_pkg::LINK_W;
  localparam int BW = pfc_pkg::BKT_W;
  localparam int PW = pfc_pkg::PIN_W;
  localparam int CW = pfc_pkg::CNT_W;
  localparam int IW = pfc_pkg::ID_W;

  pfc_pkg::state_t state_r, state_nxt;

  // Request held for the whole operation.
  logic [IW-1:0] id_r, id_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [BW-1:0] b2_r, b2_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] fnext_r, fnext_nxt;
  logic [LW-1:0] x_r, x_nxt;
  logic [CW-1:0] n_r, n_nxt;

  // Result staged until the output register frees up.
  pfc_pkg::status_t res_stat_r, res_stat_nxt;
  logic [FW-1:0]    res_frame_r, res_frame_nxt;
  logic [PW-1:0]    res_pins_r, res_pins_nxt;

  // Anchor links and counters live in flops.
  logic [LW-1:0] lru_head_r, lru_head_nxt;
  logic [LW-1:0] lru_tail_r, lru_tail_nxt;
  logic [CW-1:0] lru_total_r, lru_total_nxt;
  logic [CW-1:0] free_total_r, free_total_nxt;

  // Valid bits for the stores that reset to a known value.
  logic [pfc_pkg::HASH_BUCKETS-1:0] bkt_vld_r, bkt_vld_nxt;
  logic [pfc_pkg::FRAMES-1:0]       pin_vld_r, pin_vld_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_stat_r, out_stat_nxt;
  logic [7:0]    out_frame_r, out_frame_nxt;
  logic [15:0]   out_pins_r, out_pins_nxt;
  logic [8:0]    out_free_r, out_free_nxt;
  logic [8:0]    out_lru_r, out_lru_nxt;

  // Memory ports.
  logic          id_we;
  logic [FW-1:0] id_waddr, id_raddr;
  logic [IW-1:0] id_rdata;
  logic          pin_we;
  logic [FW-1:0] pin_waddr, pin_raddr;
  logic [PW-1:0] pin_wdata, pin_rdata;
  logic          bkt_we;
  logic [BW-1:0] bkt_waddr, bkt_raddr;
  logic [LW-1:0] bkt_wdata, bkt_rdata;
  logic          ch_we;
  logic [FW-1:0] ch_waddr, ch_raddr;
  logic [LW-1:0] ch_wdata, ch_rdata;
  logic          lp_we;
  logic [FW-1:0] lp_waddr;
  logic [LW-1:0] lp_wdata, lp_rdata;
  logic          ln_we;
  logic [FW-1:0] ln_waddr;
  logic [LW-1:0] ln_wdata, ln_rdata;
  logic [FW-1:0] lru_raddr;

  logic [IW-1:0] in_id;
  logic          in_fire;
  logic          out_free;
  logic [PW-1:0] pin_cur;
  logic [LW-1:0] bkt_cur;
  logic [LW-1:0] f_link;

  assign in_id = {in_ch.page_number, in_ch.file_id_5, in_ch.file_id_4, in_ch.file_id_3,
                  in_ch.file_id_2, in_ch.file_id_1, in_ch.file_id_0};
  assign in_ch.ready = (state_r == pfc_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign pin_cur     = pin_vld_r[f_r] ? pin_rdata : '0;
  assign f_link      = {1'b0, f_r};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.frame_index = out_frame_r;
  assign out_ch.pin_count   = out_pins_r;
  assign out_ch.free_frames = out_free_r;
  assign out_ch.lru_frames  = out_lru_r;

  pfc_ram #(.WIDTH(IW), .DEPTH(pfc_pkg::FRAMES)) u_id_ram (
    .clk, .we(id_we), .waddr(id_waddr), .wdata(id_r), .raddr(id_raddr), .rdata(id_rdata));
  pfc_ram #(.WIDTH(PW), .DEPTH(pfc_pkg::FRAMES)) u_pin_ram (
    .clk, .we(pin_we), .waddr(pin_waddr), .wdata(pin_wdata), .raddr(pin_raddr),
    .rdata(pin_rdata));
  pfc_ram #(.WIDTH(LW), .DEPTH(pfc_pkg::HASH_BUCKETS)) u_bkt_ram (
    .clk, .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata), .raddr(bkt_raddr),
    .rdata(bkt_rdata));
  pfc_ram #(.WIDTH(LW), .DEPTH(pfc_pkg::FRAMES)) u_chain_ram (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata), .raddr(ch_raddr),
    .rdata(ch_rdata));
  pfc_ram #(.WIDTH(LW), .DEPTH(pfc_pkg::FRAMES)) u_lprev_ram (
    .clk, .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata), .raddr(lru_raddr),
    .rdata(lp_rdata));
  pfc_ram #(.WIDTH(LW), .DEPTH(pfc_pkg::FRAMES)) u_lnext_ram (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata), .raddr(lru_raddr),
    .rdata(ln_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfc_pkg::ST_IDLE;
      lru_head_r   <= pfc_pkg::ANCHOR;
      lru_tail_r   <= pfc_pkg::ANCHOR;
      lru_total_r  <= '0;
      free_total_r <= CW'(pfc_pkg::FRAMES);
      bkt_vld_r    <= '0;
      pin_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lru_head_r   <= lru_head_nxt;
      lru_tail_r   <= lru_tail_nxt;
      lru_total_r  <= lru_total_nxt;
      free_total_r <= free_total_nxt;
      bkt_vld_r    <= bkt_vld_nxt;
      pin_vld_r    <= pin_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    id_r        <= id_nxt;
    b_r         <= b_nxt;
    b2_r        <= b2_nxt;
    f_r         <= f_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    fnext_r     <= fnext_nxt;
    x_r         <= x_nxt;
    n_r         <= n_nxt;
    res_stat_r  <= res_stat_nxt;
    res_frame_r <= res_frame_nxt;
    res_pins_r  <= res_pins_nxt;
    out_stat_r  <= out_stat_nxt;
    out_frame_r <= out_frame_nxt;
    out_pins_r  <= out_pins_nxt;
    out_free_r  <= out_free_nxt;
    out_lru_r   <= out_lru_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    b_nxt          = b_r;
    b2_nxt         = b2_r;
    f_nxt          = f_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    fnext_nxt      = fnext_r;
    x_nxt          = x_r;
    n_nxt          = n_r;
    res_stat_nxt   = res_stat_r;
    res_frame_nxt  = res_frame_r;
    res_pins_nxt   = res_pins_r;
    lru_head_nxt   = lru_head_r;
    lru_tail_nxt   = lru_tail_r;
    lru_total_nxt  = lru_total_r;
    free_total_nxt = free_total_r;
    bkt_vld_nxt    = bkt_vld_r;
    pin_vld_nxt    = pin_vld_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_stat_nxt   = out_stat_r;
    out_frame_nxt  = out_frame_r;
    out_pins_nxt   = out_pins_r;
    out_free_nxt   = out_free_r;
    out_lru_nxt    = out_lru_r;

    id_we     = 1'b0;
    id_waddr  = f_r;
    id_raddr  = cur_r[FW-1:0];
    pin_we    = 1'b0;
    pin_waddr = f_r;
    pin_wdata = '0;
    pin_raddr = f_r;
    bkt_we    = 1'b0;
    bkt_waddr = b_r;
    bkt_wdata = f_link;
    bkt_raddr = b_r;
    ch_we     = 1'b0;
    ch_waddr  = f_r;
    ch_wdata  = pfc_pkg::NONE;
    ch_raddr  = cur_r[FW-1:0];
    lp_we     = 1'b0;
    lp_waddr  = f_r;
    lp_wdata  = pfc_pkg::ANCHOR;
    ln_we     = 1'b0;
    ln_waddr  = f_r;
    ln_wdata  = pfc_pkg::ANCHOR;
    lru_raddr = f_r;
    bkt_cur   = pfc_pkg::NONE;

    case (state_r)
      pfc_pkg::ST_IDLE: begin
        // Start the first read of either command on the accept edge.
        bkt_raddr = pfc_pkg::bucket_of(in_id);
        pin_raddr = in_ch.release_frame[FW-1:0];
        if (in_fire) begin
          id_nxt        = in_id;
          b_nxt         = pfc_pkg::bucket_of(in_id);
          f_nxt         = in_ch.release_frame[FW-1:0];
          res_frame_nxt = '0;
          res_pins_nxt  = '0;
          if (!in_ch.cmd) begin
            state_nxt = pfc_pkg::ST_HEAD;
          end else if ({1'b0, in_ch.release_frame} >= 9'(pfc_pkg::FRAMES)) begin
            res_stat_nxt  = pfc_pkg::STAT_REL_ERR;
            res_frame_nxt = FW'(in_ch.release_frame);
            state_nxt     = pfc_pkg::ST_RESP;
          end else begin
            res_frame_nxt = in_ch.release_frame[FW-1:0];
            state_nxt     = pfc_pkg::ST_REL_RD;
          end
        end
      end

      pfc_pkg::ST_HEAD: begin
        bkt_cur = bkt_vld_r[b_r] ? bkt_rdata : pfc_pkg::NONE;
        cur_nxt = bkt_cur;
        n_nxt   = '0;
        id_raddr = bkt_cur[FW-1:0];
        ch_raddr = bkt_cur[FW-1:0];
        state_nxt = (bkt_cur == pfc_pkg::NONE) ? pfc_pkg::ST_MISS : pfc_pkg::ST_WALK;
      end

      pfc_pkg::ST_WALK: begin
        // One chain entry per cycle: compare the id, advance on the link.
        if (id_rdata == id_r) begin
          f_nxt     = cur_r[FW-1:0];
          pin_raddr = cur_r[FW-1:0];
          state_nxt = pfc_pkg::ST_HIT;
        end else begin
          cur_nxt  = ch_rdata;
          n_nxt    = n_r + 1'b1;
          id_raddr = ch_rdata[FW-1:0];
          ch_raddr = ch_rdata[FW-1:0];
          if (ch_rdata == pfc_pkg::NONE || n_r + 1'b1 == CW'(pfc_pkg::FRAMES)) begin
            state_nxt = pfc_pkg::ST_MISS;
          end
        end
      end

      pfc_pkg::ST_HIT: begin
        pin_we        = 1'b1;
        pin_wdata     = (pin_cur == pfc_pkg::PIN_MAX) ? pin_cur : pin_cur + 1'b1;
        pin_vld_nxt[f_r] = 1'b1;
        res_stat_nxt  = pfc_pkg::STAT_HIT;
        res_frame_nxt = f_r;
        res_pins_nxt  = pin_wdata;
        lru_raddr     = f_r;
        // An unpinned hashed frame sits on the LRU list: take it off.
        state_nxt = (pin_cur == '0) ? pfc_pkg::ST_UNLINK : pfc_pkg::ST_RESP;
      end

      pfc_pkg::ST_UNLINK: begin
        if (lp_rdata == pfc_pkg::ANCHOR) begin
          lru_head_nxt = ln_rdata;
        end else begin
          ln_we    = 1'b1;
          ln_waddr = lp_rdata[FW-1:0];
          ln_wdata = ln_rdata;
        end
        if (ln_rdata == pfc_pkg::ANCHOR) begin
          lru_tail_nxt = lp_rdata;
        end else begin
          lp_we    = 1'b1;
          lp_waddr = ln_rdata[FW-1:0];
          lp_wdata = lp_rdata;
        end
        if (lru_total_r != '0) begin
          lru_total_nxt = lru_total_r - 1'b1;
        end
        state_nxt = (res_stat_r == pfc_pkg::STAT_RECYCLED) ? pfc_pkg::ST_INS_RD
                                                           : pfc_pkg::ST_RESP;
      end

      pfc_pkg::ST_MISS: begin
        res_frame_nxt = '0;
        res_pins_nxt  = '0;
        if (free_total_r != '0) begin
          // Free list pops from the highest index down.
          f_nxt          = FW'(free_total_r - 1'b1);
          free_total_nxt = free_total_r - 1'b1;
          res_stat_nxt   = pfc_pkg::STAT_FREE;
          state_nxt      = pfc_pkg::ST_INS_RD;
        end else if (lru_tail_r != pfc_pkg::ANCHOR) begin
          f_nxt        = lru_tail_r[FW-1:0];
          id_raddr     = lru_tail_r[FW-1:0];
          ch_raddr     = lru_tail_r[FW-1:0];
          res_stat_nxt = pfc_pkg::STAT_RECYCLED;
          state_nxt    = pfc_pkg::ST_UH_ID;
        end else begin
          res_stat_nxt = pfc_pkg::STAT_NO_FRAME;
          state_nxt    = pfc_pkg::ST_RESP;
        end
      end

      pfc_pkg::ST_UH_ID: begin
        // Old bucket of the victim, and its successor in that chain.
        fnext_nxt = ch_rdata;
        b2_nxt    = pfc_pkg::bucket_of(id_rdata);
        bkt_raddr = pfc_pkg::bucket_of(id_rdata);
        state_nxt = pfc_pkg::ST_UH_HEAD;
      end

      pfc_pkg::ST_UH_HEAD: begin
        bkt_cur  = bkt_vld_r[b2_r] ? bkt_rdata : pfc_pkg::NONE;
        prev_nxt = bkt_cur;
        n_nxt    = '0;
        ch_raddr = bkt_cur[FW-1:0];
        if (bkt_cur == f_link) begin
          bkt_we    = 1'b1;
          bkt_waddr = b2_r;
          bkt_wdata = fnext_r;
          state_nxt = pfc_pkg::ST_UL_RD;
        end else if (bkt_cur == pfc_pkg::NONE) begin
          state_nxt = pfc_pkg::ST_UL_RD;
        end else begin
          state_nxt = pfc_pkg::ST_UH_WALK;
        end
      end

      pfc_pkg::ST_UH_WALK: begin
        prev_nxt = ch_rdata;
        n_nxt    = n_r + 1'b1;
        ch_raddr = ch_rdata[FW-1:0];
        if (ch_rdata == f_link) begin
          ch_we     = 1'b1;
          ch_waddr  = prev_r[FW-1:0];
          ch_wdata  = fnext_r;
          state_nxt = pfc_pkg::ST_UL_RD;
        end else if (ch_rdata == pfc_pkg::NONE || n_r + 1'b1 == CW'(pfc_pkg::FRAMES)) begin
          state_nxt = pfc_pkg::ST_UL_RD;
        end
      end

      pfc_pkg::ST_UL_RD: begin
        lru_raddr = f_r;
        state_nxt = pfc_pkg::ST_UNLINK;
      end

      pfc_pkg::ST_INS_RD: begin
        // Re-read the target head: unhashing may have changed it.
        bkt_raddr = b_r;
        state_nxt = pfc_pkg::ST_INS_WR;
      end

      pfc_pkg::ST_INS_WR: begin
        bkt_cur          = bkt_vld_r[b_r] ? bkt_rdata : pfc_pkg::NONE;
        ch_we            = 1'b1;
        ch_waddr         = f_r;
        ch_wdata         = bkt_cur;
        bkt_we           = 1'b1;
        bkt_waddr        = b_r;
        bkt_wdata        = f_link;
        bkt_vld_nxt[b_r] = 1'b1;
        id_we            = 1'b1;
        pin_we           = 1'b1;
        pin_wdata        = PW'(1);
        pin_vld_nxt[f_r] = 1'b1;
        res_frame_nxt    = f_r;
        res_pins_nxt     = PW'(1);
        state_nxt        = pfc_pkg::ST_RESP;
      end

      pfc_pkg::ST_REL_RD: begin
        if (pin_cur == '0) begin
          res_stat_nxt = pfc_pkg::STAT_REL_ERR;
          res_pins_nxt = '0;
          state_nxt    = pfc_pkg::ST_RESP;
        end else begin
          pin_we       = 1'b1;
          pin_wdata    = pin_cur - 1'b1;
          res_pins_nxt = pin_wdata;
          if (pin_wdata != '0) begin
            res_stat_nxt = pfc_pkg::STAT_PINNED;
            state_nxt    = pfc_pkg::ST_RESP;
          end else begin
            // Last pin dropped: link in at the LRU head.
            res_stat_nxt = pfc_pkg::STAT_UNPINNED;
            lp_we        = 1'b1;
            lp_waddr     = f_r;
            lp_wdata     = pfc_pkg::ANCHOR;
            ln_we        = 1'b1;
            ln_waddr     = f_r;
            ln_wdata     = lru_head_r;
            x_nxt        = lru_head_r;
            state_nxt    = pfc_pkg::ST_REL_PUSH;
          end
        end
      end

      pfc_pkg::ST_REL_PUSH: begin
        if (x_r == pfc_pkg::ANCHOR) begin
          lru_tail_nxt = f_link;
        end else begin
          lp_we    = 1'b1;
          lp_waddr = x_r[FW-1:0];
          lp_wdata = f_link;
        end
        lru_head_nxt  = f_link;
        lru_total_nxt = lru_total_r + 1'b1;
        state_nxt     = pfc_pkg::ST_RESP;
      end

      pfc_pkg::ST_RESP: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_frame_nxt = 8'(res_frame_r);
          out_pins_nxt  = res_pins_r;
          out_free_nxt  = 9'(free_total_r);
          out_lru_nxt   = 9'(lru_total_r);
          state_nxt     = pfc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/testbench.sv
// Testbench: self-checking random and directed test of the page frame cache.
module testbench;
  import pfc_pkg::*;

  // One request as it goes out on the request channel.
  typedef struct {
    logic                cmd;
    logic [WORD_W-1:0]   words [6];
    logic [WORD_W-1:0]   page;
    logic [FRAME_W-1:0]  rel;
  } page_req_t;

  // One answer as it comes back on the result channel.
  typedef struct {
    status_t             status;
    logic [FRAME_W-1:0]  frame;
    logic [PIN_W-1:0]    pins;
    logic [TOTAL_W-1:0]  free_cnt;
    logic [TOTAL_W-1:0]  lru_cnt;
  } page_ans_t;

  localparam logic CMD_FETCH   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam int   STALL_LIMIT = 20000;
  localparam int   LONG_HOLD   = 400;
  localparam int   SETTLE      = 24;

  logic clk;
  logic rst_n;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  page_frame_cache_lru uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the frame manager: page ids, pins, LRU list, free list, buckets.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mir_words [FRAMES][6];
  logic [WORD_W-1:0] mir_page  [FRAMES];
  bit                mir_hashed [FRAMES];
  logic [PIN_W-1:0]  mir_pins  [FRAMES];
  logic [LINK_W-1:0] lru_prev  [FRAMES+1];
  logic [LINK_W-1:0] lru_next  [FRAMES+1];
  logic [LINK_W-1:0] free_link [FRAMES];
  logic [LINK_W-1:0] free_top;
  int                free_cnt;
  logic [LINK_W-1:0] bucket_top [HASH_BUCKETS];
  logic [LINK_W-1:0] chain_link [FRAMES];
  int                lru_cnt;

  page_req_t req_queue [$];        // requests waiting for the driver
  page_ans_t expected_answers [$]; // answers predicted, oldest first
  page_req_t page_pool [$];        // ids fetched before, to produce hits

  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_requests;
  int  hold_served;
  int  hold_left;
  int  quiet_cycles;

  function automatic int bucket_index(page_req_t r);
    logic [WORD_W-1:0] s;
    s = r.page;
    for (int i = 0; i < 6; i++) s = s + r.words[i];
    return int'(s % HASH_BUCKETS);
  endfunction

  function automatic page_req_t stored_id(int f);
    page_req_t r;
    r.cmd  = CMD_FETCH;
    r.page = mir_page[f];
    r.rel  = '0;
    for (int i = 0; i < 6; i++) r.words[i] = mir_words[f][i];
    return r;
  endfunction

  function automatic void mirror_reset();
    for (int i = 0; i <= FRAMES; i++) begin
      lru_prev[i] = ANCHOR;
      lru_next[i] = ANCHOR;
    end
    for (int i = 0; i < FRAMES; i++) begin
      mir_hashed[i] = 0;
      mir_pins[i]   = '0;
      free_link[i]  = (i == 0) ? NONE : LINK_W'(i - 1);
    end
    for (int i = 0; i < HASH_BUCKETS; i++) bucket_top[i] = NONE;
    free_top = LINK_W'(FRAMES - 1);
    free_cnt = FRAMES;
    lru_cnt  = 0;
  endfunction

  // Take a frame out of its bucket chain.
  function automatic void chain_remove(int f);
    int b;
    int prev;
    int cur;
    int steps;
    b = bucket_index(stored_id(f));
    prev = NONE;
    cur = bucket_top[b];
    steps = 0;
    while (cur < FRAMES && steps < FRAMES) begin
      if (cur == f) begin
        if (prev == NONE) bucket_top[b] = chain_link[f];
        else chain_link[prev] = chain_link[f];
        break;
      end
      prev = cur;
      cur = chain_link[cur];
      steps++;
    end
    mir_hashed[f] = 0;
  endfunction

  function automatic void lru_remove(int f);
    int p;
    int x;
    p = lru_prev[f];
    x = lru_next[f];
    if (p > FRAMES || x > FRAMES) return;
    lru_next[p] = LINK_W'(x);
    lru_prev[x] = LINK_W'(p);
    if (lru_cnt > 0) lru_cnt--;
  endfunction

  function automatic void lru_push_front(int f);
    int x;
    x = lru_next[ANCHOR];
    if (x > FRAMES) x = ANCHOR;
    lru_prev[f] = ANCHOR;
    lru_next[f] = LINK_W'(x);
    lru_prev[x] = LINK_W'(f);
    lru_next[ANCHOR] = LINK_W'(f);
    lru_cnt++;
  endfunction

  // Apply one request to the mirror and return the answer it must produce.
  function automatic page_ans_t frame_manager_serve(page_req_t r);
    page_ans_t a;
    int b;
    int cur;
    int steps;
    int f;
    bit same;
    a.frame = '0;
    a.pins  = '0;
    if (r.cmd == CMD_FETCH) begin
      b = bucket_index(r);
      cur = bucket_top[b];
      steps = 0;
      f = NONE;
      while (cur < FRAMES && steps < FRAMES) begin
        same = (mir_page[cur] == r.page);
        for (int i = 0; i < 6; i++) if (mir_words[cur][i] != r.words[i]) same = 0;
        if (same) begin
          f = cur;
          break;
        end
        cur = chain_link[cur];
        steps++;
      end
      if (f != NONE) begin
        if (mir_pins[f] == 0) lru_remove(f);
        if (mir_pins[f] != PIN_MAX) mir_pins[f]++;
        a.status = STAT_HIT;
      end else begin
        if (free_top < FRAMES) begin
          f = free_top;
          free_top = free_link[f];
          if (free_cnt > 0) free_cnt--;
          a.status = STAT_FREE;
        end else if (lru_prev[ANCHOR] < FRAMES) begin
          f = lru_prev[ANCHOR];
          chain_remove(f);
          lru_remove(f);
          a.status = STAT_RECYCLED;
        end else begin
          a.status = STAT_NO_FRAME;
        end
        if (f != NONE) begin
          for (int i = 0; i < 6; i++) mir_words[f][i] = r.words[i];
          mir_page[f]   = r.page;
          chain_link[f] = bucket_top[b];
          bucket_top[b] = LINK_W'(f);
          mir_hashed[f] = 1;
          mir_pins[f]   = 1;
        end
      end
      if (f != NONE) begin
        a.frame = FRAME_W'(f);
        a.pins  = mir_pins[f];
      end
    end else begin
      f = r.rel;
      a.frame = r.rel;
      if (f >= FRAMES || mir_pins[f] == 0) begin
        a.status = STAT_REL_ERR;
      end else begin
        mir_pins[f]--;
        a.pins = mir_pins[f];
        if (mir_pins[f] == 0) begin
          if (mir_hashed[f]) lru_push_front(f);
          a.status = STAT_UNPINNED;
        end else begin
          a.status = STAT_PINNED;
        end
      end
    end
    a.free_cnt = TOTAL_W'(free_cnt);
    a.lru_cnt  = TOTAL_W'(lru_cnt);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: predict in request order, which is the order of acceptance.
  // ---------------------------------------------------------------------------
  task automatic issue(page_req_t r);
    expected_answers.push_back(frame_manager_serve(r));
    req_queue.push_back(r);
  endtask

  // Build a never-seen id; when crowded, force it into one of a few buckets so
  // that chains grow long.
  function automatic page_req_t fresh_id(bit crowded);
    page_req_t r;
    r.cmd = CMD_FETCH;
    r.rel = FRAME_W'($urandom);
    for (int i = 0; i < 6; i++) r.words[i] = $urandom;
    r.page = $urandom;
    if (crowded) begin
      r.page[7:0] = r.page[7:0] + 8'($urandom_range(3)) - 8'(bucket_index(r));
    end
    return r;
  endfunction

  task automatic fetch_new(bit crowded);
    page_req_t r;
    r = fresh_id(crowded);
    issue(r);
    page_pool.push_back(r);
    if (page_pool.size() > 320) void'(page_pool.pop_front());
  endtask

  task automatic release_frame_of(int f);
    page_req_t r;
    r = fresh_id(0);
    r.cmd = CMD_RELEASE;
    r.rel = FRAME_W'(f);
    issue(r);
  endtask

  // Release a frame that is pinned now, searching from a random start.
  task automatic release_some_pinned();
    int start;
    int f;
    start = $urandom_range(FRAMES - 1);
    f = start;
    for (int i = 0; i < FRAMES; i++) begin
      f = (start + i) % FRAMES;
      if (mir_pins[f] != 0) break;
    end
    release_frame_of(f);
  endtask

  // Hold the generator until the block has answered everything.
  task automatic wait_all_answered();
    while (req_queue.size() != 0 || expected_answers.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic random_mix(int count);
    int pick;
    page_req_t r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40 && page_pool.size() != 0) begin
        r = page_pool[$urandom_range(page_pool.size() - 1)];
        r.rel = FRAME_W'($urandom);
        issue(r);
      end else if (pick < 68) begin
        fetch_new($urandom_range(1));
      end else if (pick < 94) begin
        release_some_pinned();
      end else begin
        release_frame_of($urandom_range(FRAMES - 1));
      end
    end
  endtask

  // Pin every frame, miss once more with nothing to give, then unpin all but
  // the kept frame so the LRU list is long and recycling follows.
  task automatic exhaust_and_unpin(int keep);
    while (free_cnt != 0 || lru_cnt != 0) fetch_new($urandom_range(1));
    fetch_new(0);
    for (int f = 0; f < FRAMES; f++) begin
      if (f != keep) while (mir_pins[f] != 0) release_frame_of(f);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset.
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next request; hold it until the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= CMD_FETCH;
      in_ch.file_id_0     <= '0;
      in_ch.file_id_1     <= '0;
      in_ch.file_id_2     <= '0;
      in_ch.file_id_3     <= '0;
      in_ch.file_id_4     <= '0;
      in_ch.file_id_5     <= '0;
      in_ch.page_number   <= '0;
      in_ch.release_frame <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // Slot is free: either idle this cycle or advance to the next request.
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        page_req_t r;
        r = req_queue.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= r.cmd;
        in_ch.file_id_0     <= r.words[0];
        in_ch.file_id_1     <= r.words[1];
        in_ch.file_id_2     <= r.words[2];
        in_ch.file_id_3     <= r.words[3];
        in_ch.file_id_4     <= r.words[4];
        in_ch.file_id_5     <= r.words[5];
        in_ch.page_number   <= r.page;
        in_ch.release_frame <= r.rel;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: drive ready (random stalls, long holds) and check each answer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_served  <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: answer with none pending: expected none, actual status %0d frame %0d",
                   $realtime, out_ch.status, out_ch.frame_index);
        end else begin
          page_ans_t e;
          e = expected_answers.pop_front();
          if (out_ch.status !== e.status || out_ch.frame_index !== e.frame ||
              out_ch.pin_count !== e.pins || out_ch.free_frames !== e.free_cnt ||
              out_ch.lru_frames !== e.lru_cnt) begin
            errors++;
            $display({"%0t: expected st %0d fr %0d pin %0d free %0d lru %0d, ",
                      "actual st %0d fr %0d pin %0d free %0d lru %0d"},
                     $realtime, e.status, e.frame, e.pins, e.free_cnt, e.lru_cnt,
                     out_ch.status, out_ch.frame_index, out_ch.pin_count,
                     out_ch.free_frames, out_ch.lru_frames);
          end
        end
      end
      // A long hold lets the block fill up and stall its request side.
      if (hold_requests != hold_served) begin
        hold_served  <= hold_requests;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases.
  // ---------------------------------------------------------------------------
  initial begin
    page_req_t r;
    int sat_frame;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    quiet_cycles   = 0;
    mirror_reset();
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed: extreme ids, hits, releases down to zero, release errors.
    r = fresh_id(0);
    for (int i = 0; i < 6; i++) r.words[i] = '0;
    r.page = '0;
    r.rel  = '1;
    issue(r);
    issue(r);
    page_pool.push_back(r);
    r.rel = '0;
    for (int i = 0; i < 6; i++) r.words[i] = '1;
    r.page = '1;
    issue(r);
    page_pool.push_back(r);
    release_frame_of(FRAMES - 1);
    release_frame_of(FRAMES - 1);
    release_frame_of(FRAMES - 1);            // already unpinned
    release_frame_of(0);                     // free frame
    r = page_pool[0];
    issue(r);                                // hit taken back off the LRU list
    for (int i = 0; i < 5; i++) fetch_new(1);
    issue(page_pool[page_pool.size() - 3]);  // hit deep in a crowded chain
    release_frame_of(FRAMES - 2);
    release_frame_of(FRAMES - 2);
    r = fresh_id(0);
    r.cmd = CMD_RELEASE;
    r.rel = '1;
    for (int i = 0; i < 6; i++) r.words[i] = '1;
    r.page = '1;
    issue(r);
    wait_all_answered();

    // Repeated hits: stack many pins on one page and keep it pinned.
    fetch_new(0);
    r = page_pool[page_pool.size() - 1];
    sat_frame = expected_answers[expected_answers.size() - 1].frame;
    for (int i = 0; i < 40; i++) issue(r);
    release_frame_of(sat_frame);
    wait_all_answered();

    // No idling: exhaust frames, hit the no-frame case, then recycle.
    exhaust_and_unpin(sat_frame);
    random_mix(120);
    wait_all_answered();

    // Sender mostly idle.
    set_idling(83, 0);
    random_mix(220);
    wait_all_answered();

    // Receiver mostly stalling, with one long hold while requests keep coming.
    set_idling(0, 83);
    @(negedge clk);
    hold_requests = hold_requests + 1;
    random_mix(260);
    wait_all_answered();

    // Both idle a little.
    set_idling(13, 13);
    random_mix(420);
    wait_all_answered();

    // Back to full rate to finish.
    set_idling(0, 0);
    random_mix(100);
    wait_all_answered();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
